// ===== src/cr3_pkg.sv =====
// Shared types, widths and constants for the 3x3 Cramer solver.
package cr3_pkg;

    // Field widths and fixed-point layout
    localparam int IN_W   = 16;
    localparam int OUT_W  = 32;
    localparam int FRAC_W = 16;
    localparam int TOL_W  = 48;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(68719);

    // Datapath widths
    localparam int PROD_W = 2 * IN_W;
    localparam int COF_W  = PROD_W + 1;
    localparam int TERM_W = IN_W + COF_W;
    localparam int SUM_W  = TERM_W + 2;
    localparam int MAG_W  = SUM_W - 1;

    // Divider layout: quotient bits, integer shift, remainder width, latency.
    // The quotient keeps one bit above the signed range so the most negative
    // value comes out exact.
    localparam int QB      = OUT_W;
    localparam int ISH     = QB - FRAC_W;
    localparam int RW      = MAG_W + 1;
    localparam int DIV_LAT = QB + 3;

    typedef struct packed {
        logic signed [IN_W-1:0] a00;
        logic signed [IN_W-1:0] a01;
        logic signed [IN_W-1:0] a02;
        logic signed [IN_W-1:0] a10;
        logic signed [IN_W-1:0] a11;
        logic signed [IN_W-1:0] a12;
        logic signed [IN_W-1:0] a20;
        logic signed [IN_W-1:0] a21;
        logic signed [IN_W-1:0] a22;
        logic signed [IN_W-1:0] rhs0;
        logic signed [IN_W-1:0] rhs1;
        logic signed [IN_W-1:0] rhs2;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] sol0;
        logic signed [OUT_W-1:0] sol1;
        logic signed [OUT_W-1:0] sol2;
        logic                    solved;
        logic                    saturated;
    } t_out;

endpackage

// ===== src/cr3_div.sv =====
// Pipelined restoring divider: rounded, saturated signed fixed-point quotient.
module cr3_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [cr3_pkg::MAG_W-1:0]   i_num,
    input  logic [cr3_pkg::MAG_W-1:0]   i_den,
    input  logic                        i_neg,
    output logic [cr3_pkg::OUT_W-1:0]   o_quo,
    output logic                        o_sat
);

    logic [cr3_pkg::RW-1:0]    r_rem [0:cr3_pkg::QB];
    logic [cr3_pkg::QB-1:0]    r_low [0:cr3_pkg::QB];
    logic [cr3_pkg::QB-1:0]    r_quo [0:cr3_pkg::QB];
    logic [cr3_pkg::MAG_W-1:0] r_den [0:cr3_pkg::QB];
    logic                      r_neg [0:cr3_pkg::QB];
    logic                      r_ovf [0:cr3_pkg::QB];

    logic [cr3_pkg::OUT_W:0]   r_mag;
    logic                      r_neg_m;
    logic                      r_ovf_m;
    logic [cr3_pkg::OUT_W-1:0] r_res;
    logic                      r_sat;

    logic                      w_rnd;
    logic [cr3_pkg::OUT_W:0]   w_bound;
    logic                      w_sat;
    logic [cr3_pkg::OUT_W:0]   w_clip;

    // Load: flag quotients that cannot fit, seed remainder with the integer head
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= {cr3_pkg::ISH'(0), i_num} >= {i_den, cr3_pkg::ISH'(0)};
            r_rem[0] <= cr3_pkg::RW'(i_num >> cr3_pkg::ISH);
            r_low[0] <= {i_num[cr3_pkg::ISH-1:0], cr3_pkg::FRAC_W'(0)};
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
        end
    end

    // One quotient bit per stage
    for (genvar k = 1; k <= cr3_pkg::QB; k++) begin : g_step
        logic [cr3_pkg::RW-1:0] w_cur;
        logic                   w_ge;

        assign w_cur = {r_rem[k-1][cr3_pkg::RW-2:0], r_low[k-1][cr3_pkg::QB-1]};
        assign w_ge  = w_cur >= {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? (w_cur - {1'b0, r_den[k-1]}) : w_cur;
                r_low[k] <= {r_low[k-1][cr3_pkg::QB-2:0], 1'b0};
                r_quo[k] <= {r_quo[k-1][cr3_pkg::QB-2:0], w_ge};
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    // Round half away from zero on the magnitude
    assign w_rnd = {r_rem[cr3_pkg::QB][cr3_pkg::RW-2:0], 1'b0}
                   >= {1'b0, r_den[cr3_pkg::QB]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag   <= {1'b0, r_quo[cr3_pkg::QB]} + (cr3_pkg::OUT_W+1)'(w_rnd);
            r_neg_m <= r_neg[cr3_pkg::QB];
            r_ovf_m <= r_ovf[cr3_pkg::QB];
        end
    end

    // Clip to the signed range and apply the sign
    assign w_bound = r_neg_m ? {2'b01, (cr3_pkg::OUT_W-1)'(0)}
                             : {2'b00, {(cr3_pkg::OUT_W-1){1'b1}}};
    assign w_sat   = r_ovf_m || (r_mag > w_bound);
    assign w_clip  = w_sat ? w_bound : r_mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= r_neg_m ? (cr3_pkg::OUT_W'(0) - w_clip[cr3_pkg::OUT_W-1:0])
                             : w_clip[cr3_pkg::OUT_W-1:0];
            r_sat <= w_sat;
        end
    end

    assign o_quo = r_res;
    assign o_sat = r_sat;

endmodule

// ===== src/cramer_3x3_solver.sv =====
// Throughput: one word per cycle; five arithmetic stages feed three
// 35-stage one-bit-per-stage dividers that run side by side.
// The whole pipeline holds while a finished word waits on the output.
// Reset (synchronous, active low) empties the pipeline and sets the
// determinant tolerance to 68719.
module cramer_3x3_solver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  cr3_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output cr3_pkg::t_out               o_out_data,
    input  logic                        i_cfg_wr_en,
    input  logic [cr3_pkg::TOL_W-1:0]   i_cfg_wr_data
);

    localparam int PW = cr3_pkg::PROD_W;
    localparam int CW = cr3_pkg::COF_W;
    localparam int TW = cr3_pkg::TERM_W;
    localparam int SW = cr3_pkg::SUM_W;
    localparam int MW = cr3_pkg::MAG_W;
    localparam int DL = cr3_pkg::DIV_LAT;

    logic en;

    logic [cr3_pkg::TOL_W-1:0] r_tol;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_dv [0:DL-1];
    logic r_ds [0:DL-1];

    cr3_pkg::t_in r_in1, r_in2;
    logic signed [PW-1:0] r_p [0:11];
    logic signed [CW-1:0] r_c0, r_c1, r_c2, r_y0, r_y1, r_y2;
    logic signed [TW-1:0] r_t [0:11];
    logic signed [SW-1:0] r_det, r_nx, r_ny, r_nz;
    logic [MW-1:0] r_mdet, r_mx, r_my, r_mz;
    logic r_sdet, r_sx, r_sy, r_sz, r_ok;

    logic [cr3_pkg::OUT_W-1:0] q0, q1, q2;
    logic s0, s1, s2;

    // Advance everything unless a finished word is held
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= cr3_pkg::TOL_RESET;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    // Valid bits and solved flag travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            for (int k = 0; k < DL; k++) r_dv[k] <= 1'b0;
        end else if (en) begin
            r_v1    <= i_in_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            r_dv[0] <= r_v5;
            for (int k = 1; k < DL; k++) r_dv[k] <= r_dv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ds[0] <= r_ok;
            for (int k = 1; k < DL; k++) r_ds[k] <= r_ds[k-1];
        end
    end

    // Stage 1: two-by-two minor products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in1    <= i_in_data;
            r_p[0]   <= i_in_data.a11 * i_in_data.a22;
            r_p[1]   <= i_in_data.a21 * i_in_data.a12;
            r_p[2]   <= i_in_data.a02 * i_in_data.a21;
            r_p[3]   <= i_in_data.a01 * i_in_data.a22;
            r_p[4]   <= i_in_data.a01 * i_in_data.a12;
            r_p[5]   <= i_in_data.a02 * i_in_data.a11;
            r_p[6]   <= i_in_data.a00 * i_in_data.rhs1;
            r_p[7]   <= i_in_data.rhs0 * i_in_data.a10;
            r_p[8]   <= i_in_data.rhs0 * i_in_data.a20;
            r_p[9]   <= i_in_data.a00 * i_in_data.rhs2;
            r_p[10]  <= i_in_data.a10 * i_in_data.rhs2;
            r_p[11]  <= i_in_data.rhs1 * i_in_data.a20;
        end
    end

    // Stage 2: cofactors and right-hand minors
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in2 <= r_in1;
            r_c0  <= CW'(r_p[0])  - CW'(r_p[1]);
            r_c1  <= CW'(r_p[2])  - CW'(r_p[3]);
            r_c2  <= CW'(r_p[4])  - CW'(r_p[5]);
            r_y0  <= CW'(r_p[6])  - CW'(r_p[7]);
            r_y1  <= CW'(r_p[8])  - CW'(r_p[9]);
            r_y2  <= CW'(r_p[10]) - CW'(r_p[11]);
        end
    end

    // Stage 3: expansion terms
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t[0]  <= TW'(r_in2.a00)  * TW'(r_c0);
            r_t[1]  <= TW'(r_in2.a10)  * TW'(r_c1);
            r_t[2]  <= TW'(r_in2.a20)  * TW'(r_c2);
            r_t[3]  <= TW'(r_in2.rhs0) * TW'(r_c0);
            r_t[4]  <= TW'(r_in2.rhs1) * TW'(r_c1);
            r_t[5]  <= TW'(r_in2.rhs2) * TW'(r_c2);
            r_t[6]  <= TW'(r_in2.a22)  * TW'(r_y0);
            r_t[7]  <= TW'(r_in2.a12)  * TW'(r_y1);
            r_t[8]  <= TW'(r_in2.a02)  * TW'(r_y2);
            r_t[9]  <= TW'(r_in2.a21)  * TW'(r_y0);
            r_t[10] <= TW'(r_in2.a11)  * TW'(r_y1);
            r_t[11] <= TW'(r_in2.a01)  * TW'(r_y2);
        end
    end

    // Stage 4: determinant and the three numerators
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det <= SW'(r_t[0]) + SW'(r_t[1]) + SW'(r_t[2]);
            r_nx  <= SW'(r_t[3]) + SW'(r_t[4]) + SW'(r_t[5]);
            r_ny  <= SW'(r_t[6]) + SW'(r_t[7]) + SW'(r_t[8]);
            r_nz  <= SW'(0) - (SW'(r_t[9]) + SW'(r_t[10]) + SW'(r_t[11]));
        end
    end

    // Stage 5: magnitudes, operand signs and singular test
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mdet <= MW'(r_det[SW-1] ? (SW'(0) - r_det) : r_det);
            r_mx   <= MW'(r_nx[SW-1]  ? (SW'(0) - r_nx)  : r_nx);
            r_my   <= MW'(r_ny[SW-1]  ? (SW'(0) - r_ny)  : r_ny);
            r_mz   <= MW'(r_nz[SW-1]  ? (SW'(0) - r_nz)  : r_nz);
            r_sdet <= r_det[SW-1];
            r_sx   <= r_nx[SW-1];
            r_sy   <= r_ny[SW-1];
            r_sz   <= r_nz[SW-1];
            r_ok   <= (r_det != '0) &&
                      (MW'(r_det[SW-1] ? (SW'(0) - r_det) : r_det) >= MW'(r_tol));
        end
    end

    // Three parallel dividers
    cr3_div u_div0 (
        .i_clk (i_clk), .i_en (en), .i_num (r_mx), .i_den (r_mdet),
        .i_neg (r_sx ^ r_sdet), .o_quo (q0), .o_sat (s0)
    );
    cr3_div u_div1 (
        .i_clk (i_clk), .i_en (en), .i_num (r_my), .i_den (r_mdet),
        .i_neg (r_sy ^ r_sdet), .o_quo (q1), .o_sat (s1)
    );
    cr3_div u_div2 (
        .i_clk (i_clk), .i_en (en), .i_num (r_mz), .i_den (r_mdet),
        .i_neg (r_sz ^ r_sdet), .o_quo (q2), .o_sat (s2)
    );

    // Drive the output word; zero it when the system is singular
    assign o_out_valid          = r_dv[DL-1];
    assign o_out_data.sol0      = r_ds[DL-1] ? q0 : '0;
    assign o_out_data.sol1      = r_ds[DL-1] ? q1 : '0;
    assign o_out_data.sol2      = r_ds[DL-1] ? q2 : '0;
    assign o_out_data.solved    = r_ds[DL-1];
    assign o_out_data.saturated = r_ds[DL-1] && (s0 || s1 || s2);

endmodule
